// File: rtl/core/obx_pkg.sv
// Shared types, constants and the arctangent table for the oriented box overlap test.
// Used by the CORDIC cells, the projection pipeline and the top level.
package obx_pkg;

  localparam int TURN_W = 32;
  localparam int CORD_W = 33;
  localparam int TRIG_W = 23;
  localparam int DIFF_W = 34;
  localparam int SIZE_W = 16;
  localparam int FIELD_POS_W = 24;
  localparam int FIELD_ANG_W = 16;
  localparam int FRAC_DROP = 10;
  localparam int GAP_SHIFT = 21;
  localparam logic signed [CORD_W-1:0] CORDIC_START = 33'sd652032874;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [SIZE_W-1:0]        len1;
    logic [SIZE_W-1:0]        wid1;
    logic [SIZE_W-1:0]        len2;
    logic [SIZE_W-1:0]        wid2;
    quad_e                    quad1;
    quad_e                    quad2;
  } side_t;

  function automatic logic [TURN_W-1:0] arctan_turn(input int step);
    logic [TURN_W-1:0] r;
    unique case (step)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/obx_cordic_cell.sv
// One CORDIC rotation step with a register on its outputs.
// Depends on obx_pkg for widths and the arctangent table.
module obx_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk_i,
  input  logic signed [obx_pkg::CORD_W-1:0]   x_i,
  input  logic signed [obx_pkg::CORD_W-1:0]   y_i,
  input  logic signed [obx_pkg::CORD_W-1:0]   z_i,
  output logic signed [obx_pkg::CORD_W-1:0]   x_o,
  output logic signed [obx_pkg::CORD_W-1:0]   y_o,
  output logic signed [obx_pkg::CORD_W-1:0]   z_o
);
  import obx_pkg::*;

  localparam logic signed [CORD_W-1:0] ATAN = {1'b0, arctan_turn(STEP)};

  logic signed [CORD_W-1:0] sx, sy, x_d, y_d, z_d;
  logic signed [CORD_W-1:0] x_q, y_q, z_q;

  always_comb begin
    sx = y_i >>> STEP;
    sy = x_i >>> STEP;
    if (!z_i[CORD_W-1]) begin
      x_d = x_i - sx;
      y_d = y_i + sy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + sx;
      y_d = y_i - sy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// File: rtl/core/obx_project.sv
// Rounds the CORDIC outputs, projects both boxes on the four axes and compares.
// Five register stages; depends on obx_pkg.
module obx_project (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  obx_pkg::side_t                     side_i,
  input  logic signed [obx_pkg::CORD_W-1:0]  x1_i,
  input  logic signed [obx_pkg::CORD_W-1:0]  y1_i,
  input  logic signed [obx_pkg::CORD_W-1:0]  x2_i,
  input  logic signed [obx_pkg::CORD_W-1:0]  y2_i,
  output logic                               valid_o,
  output logic                               overlap_o
);
  import obx_pkg::*;

  localparam int PW = 2 * TRIG_W;
  localparam int NW = PW + 1;
  localparam int DPW = DIFF_W + TRIG_W;
  localparam int DW = DPW + 1;
  localparam int RPW = NW + SIZE_W;
  localparam int RW = RPW + 2;

  logic [4:0] vld_q;

  // Stage A: rounding and quadrant fold.
  logic signed [CORD_W-1:0] rx1, ry1, rx2, ry2;
  logic signed [TRIG_W-1:0] c1_d, s1_d, c2_d, s2_d;
  logic signed [TRIG_W-1:0] c1_q, s1_q, c2_q, s2_q;
  side_t sa_q;

  always_comb begin
    rx1 = (x1_i + CORD_W'(1 << (FRAC_DROP - 1))) >>> FRAC_DROP;
    ry1 = (y1_i + CORD_W'(1 << (FRAC_DROP - 1))) >>> FRAC_DROP;
    rx2 = (x2_i + CORD_W'(1 << (FRAC_DROP - 1))) >>> FRAC_DROP;
    ry2 = (y2_i + CORD_W'(1 << (FRAC_DROP - 1))) >>> FRAC_DROP;
    unique case (side_i.quad1)
      QUAD_1: begin c1_d = -TRIG_W'(ry1); s1_d = TRIG_W'(rx1); end
      QUAD_2: begin c1_d = -TRIG_W'(rx1); s1_d = -TRIG_W'(ry1); end
      QUAD_3: begin c1_d = TRIG_W'(ry1); s1_d = -TRIG_W'(rx1); end
      default: begin c1_d = TRIG_W'(rx1); s1_d = TRIG_W'(ry1); end
    endcase
    unique case (side_i.quad2)
      QUAD_1: begin c2_d = -TRIG_W'(ry2); s2_d = TRIG_W'(rx2); end
      QUAD_2: begin c2_d = -TRIG_W'(rx2); s2_d = -TRIG_W'(ry2); end
      QUAD_3: begin c2_d = TRIG_W'(ry2); s2_d = -TRIG_W'(rx2); end
      default: begin c2_d = TRIG_W'(rx2); s2_d = TRIG_W'(ry2); end
    endcase
  end

  always_ff @(posedge clk_i) begin
    c1_q <= c1_d;
    s1_q <= s1_d;
    c2_q <= c2_d;
    s2_q <= s2_d;
    sa_q <= side_i;
  end

  // Stage B: trig products and centre offset products.
  logic signed [PW-1:0] c1c1_q, s1s1_q, c2c2_q, s2s2_q, c1c2_q, s1s2_q, c1s2_q, s1c2_q;
  logic signed [DPW-1:0] xc1_q, ys1_q, xs1_q, yc1_q, xc2_q, ys2_q, xs2_q, yc2_q;
  logic [SIZE_W-1:0] lb1_q, wb1_q, lb2_q, wb2_q;

  always_ff @(posedge clk_i) begin
    c1c1_q <= c1_q * c1_q;
    s1s1_q <= s1_q * s1_q;
    c2c2_q <= c2_q * c2_q;
    s2s2_q <= s2_q * s2_q;
    c1c2_q <= c1_q * c2_q;
    s1s2_q <= s1_q * s2_q;
    c1s2_q <= c1_q * s2_q;
    s1c2_q <= s1_q * c2_q;
    xc1_q  <= sa_q.dx * c1_q;
    ys1_q  <= sa_q.dy * s1_q;
    xs1_q  <= sa_q.dx * s1_q;
    yc1_q  <= sa_q.dy * c1_q;
    xc2_q  <= sa_q.dx * c2_q;
    ys2_q  <= sa_q.dy * s2_q;
    xs2_q  <= sa_q.dx * s2_q;
    yc2_q  <= sa_q.dy * c2_q;
    lb1_q  <= sa_q.len1;
    wb1_q  <= sa_q.wid1;
    lb2_q  <= sa_q.len2;
    wb2_q  <= sa_q.wid2;
  end

  // Stage C: dot and cross sums, magnitudes.
  logic signed [NW-1:0] n1, n2, dp, cr;
  logic signed [DW-1:0] d0, d1, d2, d3;
  logic [NW-1:0] n1_q, n2_q, adp_q, acr_q;
  logic [DW-1:0] ad0_q, ad1_q, ad2_q, ad3_q;
  logic [SIZE_W-1:0] lc1_q, wc1_q, lc2_q, wc2_q;

  always_comb begin
    n1 = NW'(c1c1_q) + NW'(s1s1_q);
    n2 = NW'(c2c2_q) + NW'(s2s2_q);
    dp = NW'(c1c2_q) + NW'(s1s2_q);
    cr = NW'(c1s2_q) - NW'(s1c2_q);
    d0 = DW'(xc1_q) + DW'(ys1_q);
    d1 = DW'(yc1_q) - DW'(xs1_q);
    d2 = DW'(xc2_q) + DW'(ys2_q);
    d3 = DW'(yc2_q) - DW'(xs2_q);
  end

  always_ff @(posedge clk_i) begin
    n1_q  <= n1;
    n2_q  <= n2;
    adp_q <= dp[NW-1] ? -dp : dp;
    acr_q <= cr[NW-1] ? -cr : cr;
    ad0_q <= d0[DW-1] ? -d0 : d0;
    ad1_q <= d1[DW-1] ? -d1 : d1;
    ad2_q <= d2[DW-1] ? -d2 : d2;
    ad3_q <= d3[DW-1] ? -d3 : d3;
    lc1_q <= lb1_q;
    wc1_q <= wb1_q;
    lc2_q <= lb2_q;
    wc2_q <= wb2_q;
  end

  // Stage D: size times projected extent.
  logic [RPW-1:0] l1n1_q, w1n1_q, l2n2_q, w2n2_q;
  logic [RPW-1:0] l1dp_q, w1dp_q, l2dp_q, w2dp_q, l1cr_q, w1cr_q, l2cr_q, w2cr_q;
  logic [DW-1:0] ae0_q, ae1_q, ae2_q, ae3_q;

  always_ff @(posedge clk_i) begin
    l1n1_q <= lc1_q * n1_q;
    w1n1_q <= wc1_q * n1_q;
    l2n2_q <= lc2_q * n2_q;
    w2n2_q <= wc2_q * n2_q;
    l1dp_q <= lc1_q * adp_q;
    w1dp_q <= wc1_q * adp_q;
    l2dp_q <= lc2_q * adp_q;
    w2dp_q <= wc2_q * adp_q;
    l1cr_q <= lc1_q * acr_q;
    w1cr_q <= wc1_q * acr_q;
    l2cr_q <= lc2_q * acr_q;
    w2cr_q <= wc2_q * acr_q;
    ae0_q  <= ad0_q;
    ae1_q  <= ad1_q;
    ae2_q  <= ad2_q;
    ae3_q  <= ad3_q;
  end

  // Stage E: reach sums and gap compare on every axis.
  logic [RW-1:0] r0, r1, r2, r3;
  logic gap;
  logic overlap_q;

  always_comb begin
    r0 = RW'(l1n1_q) + RW'(l2dp_q) + RW'(w2cr_q);
    r1 = RW'(w1n1_q) + RW'(l2cr_q) + RW'(w2dp_q);
    r2 = RW'(l1dp_q) + RW'(w1cr_q) + RW'(l2n2_q);
    r3 = RW'(l1cr_q) + RW'(w1dp_q) + RW'(w2n2_q);
    gap = (RW'(ae0_q) > (r0 >> GAP_SHIFT)) || (RW'(ae1_q) > (r1 >> GAP_SHIFT)) ||
          (RW'(ae2_q) > (r2 >> GAP_SHIFT)) || (RW'(ae3_q) > (r3 >> GAP_SHIFT));
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= !gap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o   = vld_q[4];
  assign overlap_o = overlap_q;

endmodule

// File: rtl/core/oriented_box_overlap_test_top.sv
// Top level of the oriented box overlap test: two CORDIC cell chains and the projection pipeline.
// Depends on obx_pkg, obx_cordic_cell and obx_project.
//
// Usage: drive both boxes on the input ports and raise start_i; an item is
// taken at every rising edge where start_i is high and busy_o is low.
// busy_o stays low, so a new item may enter in every cycle.
// Once an item has passed the CORDIC chain and the projection stages, valid_o
// is high for one cycle and overlap_o holds its answer: one for overlapping or
// touching boxes, zero for separated boxes.
// Each item passes a chain of TRIG_STEPS CORDIC cells, one rotation per
// cell for both headings side by side, followed by five stages of rounding,
// products, sums and the gap compare. The block takes one item per cycle.
// Reset clears all valid flags; items in flight are dropped and no result
// is shown for them. Results cannot be held off by the receiver, so they
// must be taken in the cycle they appear.
module oriented_box_overlap_test_top #(
  parameter int ANGLE_BITS = 16,
  parameter int POSITION_BITS = 24,
  parameter int TRIG_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [23:0]  first_center_x_i,
  input  logic signed [23:0]  first_center_y_i,
  input  logic [15:0]         first_heading_i,
  input  logic [15:0]         first_width_i,
  input  logic [15:0]         first_length_i,
  input  logic signed [23:0]  second_center_x_i,
  input  logic signed [23:0]  second_center_y_i,
  input  logic [15:0]         second_heading_i,
  input  logic [15:0]         second_width_i,
  input  logic [15:0]         second_length_i,
  output logic                valid_o,
  output logic                overlap_o
);
  import obx_pkg::*;

  localparam int PAD = 32 - FIELD_POS_W;

  logic accept;
  logic [31:0] px1, py1, px2, py2;
  logic signed [POSITION_BITS-1:0] tx1, ty1, tx2, ty2;
  logic [TURN_W-1:0] hw1, hw2, turn1, turn2;
  side_t side_in;

  logic signed [CORD_W-1:0] x1 [TRIG_STEPS+1];
  logic signed [CORD_W-1:0] y1 [TRIG_STEPS+1];
  logic signed [CORD_W-1:0] z1 [TRIG_STEPS+1];
  logic signed [CORD_W-1:0] x2 [TRIG_STEPS+1];
  logic signed [CORD_W-1:0] y2 [TRIG_STEPS+1];
  logic signed [CORD_W-1:0] z2 [TRIG_STEPS+1];
  side_t side_q [TRIG_STEPS];
  logic [TRIG_STEPS-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    px1 = {{PAD{first_center_x_i[FIELD_POS_W-1]}}, first_center_x_i};
    py1 = {{PAD{first_center_y_i[FIELD_POS_W-1]}}, first_center_y_i};
    px2 = {{PAD{second_center_x_i[FIELD_POS_W-1]}}, second_center_x_i};
    py2 = {{PAD{second_center_y_i[FIELD_POS_W-1]}}, second_center_y_i};
    tx1 = px1[POSITION_BITS-1:0];
    ty1 = py1[POSITION_BITS-1:0];
    tx2 = px2[POSITION_BITS-1:0];
    ty2 = py2[POSITION_BITS-1:0];
    hw1 = TURN_W'(first_heading_i);
    hw2 = TURN_W'(second_heading_i);
    turn1 = {hw1[ANGLE_BITS-1:0], {(TURN_W-ANGLE_BITS){1'b0}}};
    turn2 = {hw2[ANGLE_BITS-1:0], {(TURN_W-ANGLE_BITS){1'b0}}};
    side_in.dx    = DIFF_W'(tx2) - DIFF_W'(tx1);
    side_in.dy    = DIFF_W'(ty2) - DIFF_W'(ty1);
    side_in.len1  = first_length_i;
    side_in.wid1  = first_width_i;
    side_in.len2  = second_length_i;
    side_in.wid2  = second_width_i;
    side_in.quad1 = quad_e'(turn1[TURN_W-1 -: 2]);
    side_in.quad2 = quad_e'(turn2[TURN_W-1 -: 2]);
  end

  assign x1[0] = CORDIC_START;
  assign y1[0] = '0;
  assign z1[0] = {3'b000, turn1[TURN_W-3:0]};
  assign x2[0] = CORDIC_START;
  assign y2[0] = '0;
  assign z2[0] = {3'b000, turn2[TURN_W-3:0]};

  for (genvar g = 0; g < TRIG_STEPS; g++) begin : g_chain
    obx_cordic_cell #(.STEP(g)) u_cell1 (
      .clk_i (clk_i),
      .x_i   (x1[g]),
      .y_i   (y1[g]),
      .z_i   (z1[g]),
      .x_o   (x1[g+1]),
      .y_o   (y1[g+1]),
      .z_o   (z1[g+1])
    );
    obx_cordic_cell #(.STEP(g)) u_cell2 (
      .clk_i (clk_i),
      .x_i   (x2[g]),
      .y_i   (y2[g]),
      .z_i   (z2[g]),
      .x_o   (x2[g+1]),
      .y_o   (y2[g+1]),
      .z_o   (z2[g+1])
    );
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        side_q[g] <= side_in;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        side_q[g] <= side_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TRIG_STEPS-2:0], accept};
    end
  end

  obx_project u_project (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld_q[TRIG_STEPS-1]),
    .side_i    (side_q[TRIG_STEPS-1]),
    .x1_i      (x1[TRIG_STEPS]),
    .y1_i      (y1[TRIG_STEPS]),
    .x2_i      (x2[TRIG_STEPS]),
    .y2_i      (y2[TRIG_STEPS]),
    .valid_o   (valid_o),
    .overlap_o (overlap_o)
  );

endmodule

// File: rtl/core/obx_checker.sv
// Port-level checks for the oriented box overlap test, bound to the top level.
// Depends only on the top level's ports.
module obx_checker #(
  parameter int TRIG_STEPS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o,
  input logic overlap_o
);
  localparam int LAT = TRIG_STEPS + 5;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("The block refused an item.");

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT valid_o)
    else $error("An accepted item produced no result.");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("A result appeared without an accepted item.");

  a_overlap_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (overlap_o == 1'b0 || overlap_o == 1'b1))
    else $error("The overlap flag is not a clean bit.");

endmodule

bind oriented_box_overlap_test_top obx_checker #(.TRIG_STEPS(TRIG_STEPS)) u_obx_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .valid_o   (valid_o),
  .overlap_o (overlap_o)
);

// File: dv/oriented_box_overlap_test_top_tb.sv
// Testbench for oriented_box_overlap_test_top: drives box pairs, predicts the overlap
// answer with its own CORDIC and separating axis computation, and checks every result.
// Depends on obx_pkg and the oriented_box_overlap_test_top RTL.
`timescale 1ns / 100ps

module oriented_box_overlap_test_top_tb;
  import obx_pkg::*;

  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [15:0]        hd;
    logic [15:0]        wd;
    logic [15:0]        ln;
  } box_t;

  localparam longint unsigned ATAN_TURN [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
  };
  localparam int TIMEOUT_CYCLES = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [23:0] first_center_x_i = '0, first_center_y_i = '0;
  logic signed [23:0] second_center_x_i = '0, second_center_y_i = '0;
  logic [15:0] first_heading_i = '0, first_width_i = '0, first_length_i = '0;
  logic [15:0] second_heading_i = '0, second_width_i = '0, second_length_i = '0;
  logic valid_o;
  logic overlap_o;

  bit expected_overlaps[$];
  int errors = 0;
  int cycles = 0;
  int hits_seen = 0;
  int gaps_seen = 0;
  bit allow_idle = 1'b1;

  oriented_box_overlap_test_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_center_x_i, .first_center_y_i, .first_heading_i,
    .first_width_i, .first_length_i,
    .second_center_x_i, .second_center_y_i, .second_heading_i,
    .second_width_i, .second_length_i,
    .valid_o, .overlap_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_overlaps.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void heading_trig(input logic [15:0] hd, output longint cs,
                                       output longint sn);
    logic [31:0] turn;
    longint x, y, z, dx, dy, c, s;
    turn = {hd, 16'h0000};
    x = CORDIC_START;
    y = 0;
    z = longint'(turn[29:0]);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end
    end
    c = (x + 512) >>> FRAC_DROP;
    s = (y + 512) >>> FRAC_DROP;
    case (quad_e'(turn[31:30]))
      QUAD_1: begin cs = -s; sn = c; end
      QUAD_2: begin cs = -c; sn = -s; end
      QUAD_3: begin cs = s; sn = -c; end
      default: begin cs = c; sn = s; end
    endcase
  endfunction

  function automatic longint corner_reach(longint ln, longint wd, longint c, longint s,
                                          longint ux, longint uy);
    longint best, sl, sw, ox, oy, p;
    best = 0;
    for (int k = 0; k < 4; k++) begin
      sl = k[0] ? -1 : 1;
      sw = k[1] ? -1 : 1;
      ox = sl * ln * c - sw * wd * s;
      oy = sl * ln * s + sw * wd * c;
      p = ox * ux + oy * uy;
      if (k == 0 || p > best) best = p;
    end
    return best;
  endfunction

  function automatic bit boxes_overlap(box_t a, box_t b);
    longint c1, s1, c2, s2, dx, dy, r, d;
    longint ax [4];
    longint ay [4];
    heading_trig(a.hd, c1, s1);
    heading_trig(b.hd, c2, s2);
    dx = longint'(b.cx) - longint'(a.cx);
    dy = longint'(b.cy) - longint'(a.cy);
    ax = '{c1, -s1, c2, -s2};
    ay = '{s1, c1, s2, c2};
    for (int i = 0; i < 4; i++) begin
      r = corner_reach(a.ln, a.wd, c1, s1, ax[i], ay[i])
        + corner_reach(b.ln, b.wd, c2, s2, ax[i], ay[i]);
      d = dx * ax[i] + dy * ay[i];
      if (d < 0) d = -d;
      if (d > (r >>> GAP_SHIFT)) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (valid_o) begin
      if (expected_overlaps.size() == 0) begin
        $display("%0t: unexpected result overlap=%0b", $time, overlap_o);
        errors++;
      end else begin
        if (overlap_o !== expected_overlaps[0]) begin
          $display("%0t: overlap mismatch expected %0b actual %0b", $time,
                   expected_overlaps[0], overlap_o);
          errors++;
        end
        if (expected_overlaps[0]) hits_seen++; else gaps_seen++;
        void'(expected_overlaps.pop_front());
      end
    end
  end

  task automatic send_pair(box_t a, box_t b);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    first_center_x_i = a.cx; first_center_y_i = a.cy; first_heading_i = a.hd;
    first_width_i = a.wd; first_length_i = a.ln;
    second_center_x_i = b.cx; second_center_y_i = b.cy; second_heading_i = b.hd;
    second_width_i = b.wd; second_length_i = b.ln;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    expected_overlaps = {expected_overlaps, boxes_overlap(a, b)};
  endtask

  function automatic box_t random_box();
    box_t b;
    b.cx = 24'($urandom); b.cy = 24'($urandom); b.hd = 16'($urandom);
    b.wd = 16'($urandom); b.ln = 16'($urandom);
    return b;
  endfunction

  function automatic box_t make_box(int cx, int cy, int hd, int wd, int ln);
    box_t b;
    b.cx = 24'(cx); b.cy = 24'(cy); b.hd = 16'(hd); b.wd = 16'(wd); b.ln = 16'(ln);
    return b;
  endfunction

  task automatic test_extremes();
    send_pair(make_box(-8388608, -8388608, 0, 65535, 65535),
              make_box(8388607, 8388607, 65535, 65535, 65535));
    send_pair(make_box(8388607, -8388608, 32768, 0, 0),
              make_box(-8388608, 8388607, 16384, 0, 0));
    send_pair(make_box(0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0));
    send_pair(make_box(0, 0, 12345, 0, 1000), make_box(100, 50, 54321, 1000, 0));
    send_pair(make_box(0, 0, 0, 65535, 65535), make_box(1, -1, 8192, 65535, 65535));
  endtask

  task automatic test_quadrants();
    int hd [6] = '{16384, 32768, 49152, 65535, 8192, 40960};
    foreach (hd[i]) begin
      send_pair(make_box(0, 0, hd[i], 512, 1024), make_box(700, 300, hd[5 - i], 256, 512));
      send_pair(make_box(0, 0, hd[i], 512, 1024), make_box(3000, 0, hd[i], 512, 1024));
    end
  endtask

  task automatic test_touching();
    send_pair(make_box(0, 0, 0, 512, 512), make_box(512, 0, 0, 512, 512));
    send_pair(make_box(0, 0, 0, 512, 512), make_box(513, 0, 0, 512, 512));
    send_pair(make_box(0, 0, 16384, 512, 512), make_box(0, 512, 16384, 512, 512));
    send_pair(make_box(0, 0, 0, 0, 512), make_box(256, 0, 0, 0, 0));
    send_pair(make_box(0, 0, 0, 0, 512), make_box(257, 0, 0, 0, 0));
  endtask

  task automatic test_random_pairs(int count);
    box_t a, b;
    repeat (count) begin
      a = random_box();
      b = random_box();
      if ($urandom_range(0, 4) != 0) begin
        a.wd = 16'($urandom_range(0, 4095)); a.ln = 16'($urandom_range(0, 4095));
        b.wd = 16'($urandom_range(0, 4095)); b.ln = 16'($urandom_range(0, 4095));
        b.cx = 24'(a.cx + $urandom_range(0, 8191) - 4096);
        b.cy = 24'(a.cy + $urandom_range(0, 8191) - 4096);
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_quadrants();
    test_touching();
    test_random_pairs(700);
    allow_idle = 1'b0;
    test_random_pairs(200);
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_overlaps.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d overlapping and %0d separated box pairs,", hits_seen, gaps_seen);
    $display("covering extremes, all quadrants, touching edges and random streams.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/obx_pkg.sv
rtl/core/obx_cordic_cell.sv
rtl/core/obx_project.sv
rtl/core/oriented_box_overlap_test_top.sv
rtl/core/obx_checker.sv
dv/oriented_box_overlap_test_top_tb.sv
